@@ rtl/isometric_back_to_front_cell_walker_core_defines.svh @@
// assertion macros for the isometric back-to-front cell walker
// no dependencies; included by the modules that carry assertions
`ifndef ISOMETRIC_BACK_TO_FRONT_CELL_WALKER_CORE_DEFINES_SVH
`define ISOMETRIC_BACK_TO_FRONT_CELL_WALKER_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define IBFCW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ibfcw assertion failed");
// next-cycle implication
`define IBFCW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ibfcw assertion failed");
`else
`define IBFCW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IBFCW_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/ibfcw_pkg.sv @@
// types and constants for the isometric back-to-front cell walker
// no dependencies; imported by isometric_back_to_front_cell_walker_core
package ibfcw_pkg;

    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 1;
    localparam int WIN_W       = 13;
    localparam int ANCHOR_W    = 15;
    localparam int CELL_W      = 16;
    localparam int SCREEN_W    = 14;

    localparam int WIN_LIMIT    = 4096;
    localparam int REACH_MARGIN = 3;

    localparam logic [WIN_W-1:0] WIN_LIMIT_V   = 13'd4096;
    localparam logic [WIN_W-1:0] WIN_W_RESET   = 13'd640;
    localparam logic [WIN_W-1:0] WIN_H_RESET   = 13'd480;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WIN_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIN_HEIGHT = 1'b1;

    // operation codes carried in tuser
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic                       visible;
        logic signed [CELL_W-1:0]   cell_x;
        logic signed [CELL_W-1:0]   cell_y;
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y;
        logic                       done_res;
    } t_result;

endpackage

@@ rtl/isometric_back_to_front_cell_walker_core.sv @@
// isometric back-to-front cell walker: one walk step per advance item
// depends on ibfcw_pkg and isometric_back_to_front_cell_walker_core_defines.svh
// each result is registered in the output register, or in the skid entry while the output stalls
// throughput: one item per cycle while the skid entry is empty, set by the single step of the walk counters
// a two-entry output buffer keeps the input side open while one result waits
// reset: synchronous active low; clears the walk, the buffer and restores 640x480
`include "isometric_back_to_front_cell_walker_core_defines.svh"

module isometric_back_to_front_cell_walker_core #(
    parameter int TILE_WIDTH      = 64,
    parameter int TILE_HEIGHT     = 64,
    parameter int STEP_HORIZONTAL = 32,
    parameter int STEP_VERTICAL   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ibfcw_pkg::IN_DATA_W-1:0]    i_s_tdata,  // player_x, player_y, zero pad
    input  logic                               i_s_tuser,  // operation
    // result items
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ibfcw_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // cell_x, cell_y, screen_x, screen_y, pad
    output logic                               o_m_tuser,  // visible
    output logic                               o_m_tlast,  // done_res
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ibfcw_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ibfcw_pkg::WIN_W-1:0]        i_cfg_data
);
    import ibfcw_pkg::*;

    localparam int RMAX = WIN_LIMIT / (2 * STEP_HORIZONTAL) + WIN_LIMIT / (2 * STEP_VERTICAL)
                          + 2 * REACH_MARGIN;
    localparam int RW   = $clog2(RMAX + 1);
    localparam int OW   = $clog2(4 * RMAX + 1);
    localparam int SW   = $clog2(4 * RMAX * (STEP_HORIZONTAL + STEP_VERTICAL) + 4 * WIN_LIMIT
                          + TILE_WIDTH + TILE_HEIGHT + 32768) + 2;
    localparam int WSH  = $clog2(2 * STEP_HORIZONTAL);
    localparam int HSH  = $clog2(2 * STEP_VERTICAL);
    localparam int XSH  = $clog2(STEP_HORIZONTAL);
    localparam int YSH  = $clog2(STEP_VERTICAL);

    localparam logic signed [SW-1:0] HALF_TW = SW'(TILE_WIDTH / 2);
    localparam logic signed [SW-1:0] HALF_TH = SW'(TILE_HEIGHT / 2);
    localparam logic signed [SW-1:0] TW_S    = SW'(TILE_WIDTH);
    localparam logic signed [SW-1:0] TH_S    = SW'(TILE_HEIGHT);
    localparam logic [RW-1:0]        MARGIN2 = RW'(2 * REACH_MARGIN);

    // configuration
    logic [WIN_W-1:0] r_win_w, r_win_h;
    logic [WIN_W-1:0] win_wc, win_hc;

    // walk state
    logic                       r_active, n_active;
    logic [OW-1:0]              r_dofs, n_dofs;
    logic [OW-1:0]              r_cofs, n_cofs;
    logic [RW-1:0]              r_reach, n_reach;
    logic signed [ANCHOR_W-1:0] r_ax, n_ax;
    logic signed [ANCHOR_W-1:0] r_ay, n_ay;

    // output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result res;

    logic                       acc;
    logic                       in_op;
    logic signed [ANCHOR_W-1:0] in_px, in_py;
    logic [RW-1:0]              start_reach;

    logic signed [SW-1:0] r_s, depth, col, dmc, k, cx, cy, sx, sy, w_s, h_s;
    logic                 in_band, on_screen, col_end, depth_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w <= WIN_W_RESET;
            r_win_h <= WIN_H_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_WIN_WIDTH:  r_win_w <= i_cfg_data;
                CFG_WIN_HEIGHT: r_win_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign win_wc = (r_win_w > WIN_LIMIT_V) ? WIN_LIMIT_V : r_win_w;
    assign win_hc = (r_win_h > WIN_LIMIT_V) ? WIN_LIMIT_V : r_win_h;
    assign w_s    = $signed({{(SW-WIN_W){1'b0}}, win_wc});
    assign h_s    = $signed({{(SW-WIN_W){1'b0}}, win_hc});

    assign o_s_tready = !r_skid_valid;
    assign acc        = i_s_tvalid && o_s_tready;
    assign in_op      = i_s_tuser;
    assign in_px      = i_s_tdata[ANCHOR_W-1:0];
    assign in_py      = i_s_tdata[2*ANCHOR_W-1:ANCHOR_W];

    assign start_reach = RW'(win_wc >> WSH) + RW'(win_hc >> HSH) + MARGIN2;

    // walk position relative to the anchor
    assign r_s   = $signed({{(SW-RW){1'b0}}, r_reach});
    assign depth = $signed({{(SW-OW){1'b0}}, r_dofs}) - (r_s <<< 1);
    assign col   = $signed({{(SW-OW){1'b0}}, r_cofs}) - r_s;
    assign dmc   = depth - col;
    assign k     = (col <<< 1) - depth;
    assign cx    = $signed({{(SW-ANCHOR_W){r_ax[ANCHOR_W-1]}}, r_ax}) + col;
    assign cy    = $signed({{(SW-ANCHOR_W){r_ay[ANCHOR_W-1]}}, r_ay}) + dmc;

    // isometric projection around the window centre
    assign sx = (w_s >>> 1) - HALF_TW + (k <<< XSH);
    assign sy = (h_s >>> 1) - HALF_TH + (depth <<< YSH);

    assign in_band   = (dmc >= -r_s) && (dmc <= r_s);
    assign on_screen = !(sx < -TW_S || sx > w_s) && !(sy < -TH_S || sy > h_s);
    assign col_end   = (col >= r_s);
    assign depth_end = (depth >= (r_s <<< 1));

    always_comb begin
        n_active = r_active;
        n_dofs   = r_dofs;
        n_cofs   = r_cofs;
        n_reach  = r_reach;
        n_ax     = r_ax;
        n_ay     = r_ay;
        res      = '0;
        if (in_op == OP_START) begin
            n_ax     = in_px;
            n_ay     = in_py;
            n_reach  = start_reach;
            n_dofs   = '0;
            n_cofs   = '0;
            n_active = 1'b1;
        end else if (!r_active) begin
            res.done_res = 1'b1;
        end else begin
            if (in_band && on_screen) begin
                res.visible  = 1'b1;
                res.cell_x   = cx[CELL_W-1:0];
                res.cell_y   = cy[CELL_W-1:0];
                res.screen_x = sx[SCREEN_W-1:0];
                res.screen_y = sy[SCREEN_W-1:0];
            end
            if (col_end) begin
                n_cofs = '0;
                if (depth_end) begin
                    res.done_res = 1'b1;
                    n_active     = 1'b0;
                end else begin
                    n_dofs = r_dofs + 1'b1;
                end
            end else begin
                n_cofs = r_cofs + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_dofs   <= '0;
            r_cofs   <= '0;
            r_reach  <= '0;
            r_ax     <= '0;
            r_ay     <= '0;
        end else if (acc) begin
            r_active <= n_active;
            r_dofs   <= n_dofs;
            r_cofs   <= n_cofs;
            r_reach  <= n_reach;
            r_ax     <= n_ax;
            r_ay     <= n_ay;
        end
    end

    // output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= acc;
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out <= res;
        end else if (acc) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.visible;
    assign o_m_tlast  = r_out.done_res;
    assign o_m_tdata  = {{(OUT_DATA_W - 2*CELL_W - 2*SCREEN_W){1'b0}},
                         r_out.screen_y, r_out.screen_x, r_out.cell_y, r_out.cell_x};

    `IBFCW_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `IBFCW_ASSERT_NXT(a_start_clears, i_clk, i_rst_n, acc && in_op == OP_START,
        r_active && r_dofs == '0 && r_cofs == '0)
    `IBFCW_ASSERT_IMP(a_col_bound, i_clk, i_rst_n, r_active,
        {1'b0, r_cofs} <= ({{(OW+1-RW){1'b0}}, r_reach} <<< 1))
    `IBFCW_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, r_active,
        {1'b0, r_dofs} <= ({{(OW+1-RW){1'b0}}, r_reach} <<< 2))
    `IBFCW_ASSERT_NXT(a_idle_done, i_clk, i_rst_n,
        acc && in_op == OP_ADVANCE && !r_active && !r_out_valid, r_out_valid && r_out.done_res)

endmodule

@@ sim/ibfcw_walk_checker.sv @@
// checker for the isometric back-to-front cell walker: watches the item, result and
// configuration channels, predicts each result and compares it field by field
// depends on ibfcw_pkg
module ibfcw_walk_checker #(
    parameter int TILE_WIDTH      = 64,
    parameter int TILE_HEIGHT     = 64,
    parameter int STEP_HORIZONTAL = 32,
    parameter int STEP_VERTICAL   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [ibfcw_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                               i_s_tuser,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [ibfcw_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input  logic                               i_m_tuser,
    input  logic                               i_m_tlast,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [ibfcw_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ibfcw_pkg::WIN_W-1:0]        i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ibfcw_pkg::*;

    logic [WIN_W-1:0]           win_width;
    logic [WIN_W-1:0]           win_height;
    logic                       walking;
    logic [9:0]                 depth_step;
    logic [9:0]                 column_step;
    logic [8:0]                 reach;
    logic signed [ANCHOR_W-1:0] anchor_x;
    logic signed [ANCHOR_W-1:0] anchor_y;

    t_result expected_cells[$];
    int      fail_count  = 0;
    int      pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    // anything above the limit is treated as the limit, zero stays zero
    function automatic int usable_window(input logic [WIN_W-1:0] v);
        return (v > WIN_LIMIT_V) ? WIN_LIMIT : int'(v);
    endfunction

    function automatic t_result walk_step(input logic op,
                                          input logic signed [ANCHOR_W-1:0] px,
                                          input logic signed [ANCHOR_W-1:0] py);
        t_result res;
        int w, h, r, depth, c, cx, cy, sx, sy;
        res = '0;
        w   = usable_window(win_width);
        h   = usable_window(win_height);
        if (op == OP_START) begin
            anchor_x    = px;
            anchor_y    = py;
            reach       = 9'((w / (2 * STEP_HORIZONTAL) + REACH_MARGIN) +
                             (h / (2 * STEP_VERTICAL) + REACH_MARGIN));
            depth_step  = '0;
            column_step = '0;
            walking     = 1'b1;
            return res;
        end
        if (!walking) begin
            res.done_res = 1'b1;
            return res;
        end
        r     = int'(reach);
        depth = int'(depth_step) - 2 * r;
        c     = int'(column_step) - r;
        cx    = anchor_x + c;
        cy    = anchor_y + depth - c;
        // only cells whose row stays inside the square around the player
        if (depth - c >= -r && depth - c <= r) begin
            sx = w / 2 - TILE_WIDTH / 2 + (2 * c - depth) * STEP_HORIZONTAL;
            sy = h / 2 - TILE_HEIGHT / 2 + depth * STEP_VERTICAL;
            if (!(sx + TILE_WIDTH < 0 || sx > w) && !(sy + TILE_HEIGHT < 0 || sy > h)) begin
                res.visible  = 1'b1;
                res.cell_x   = CELL_W'(cx);
                res.cell_y   = CELL_W'(cy);
                res.screen_x = SCREEN_W'(sx);
                res.screen_y = SCREEN_W'(sy);
            end
        end
        if (int'(column_step) >= 2 * r) begin
            if (int'(depth_step) >= 4 * r) begin
                res.done_res = 1'b1;
                walking      = 1'b0;
            end else begin
                depth_step = depth_step + 1'b1;
            end
            column_step = '0;
        end else begin
            column_step = column_step + 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_result                    want;
        logic signed [CELL_W-1:0]   got_cx;
        logic signed [CELL_W-1:0]   got_cy;
        logic signed [SCREEN_W-1:0] got_sx;
        logic signed [SCREEN_W-1:0] got_sy;
        got_cx = i_m_tdata[15:0];
        got_cy = i_m_tdata[31:16];
        got_sx = i_m_tdata[45:32];
        got_sy = i_m_tdata[59:46];
        if (expected_cells.size() == 0) begin
            $error("result item with no expectation waiting");
            fail_count++;
        end else begin
            want = expected_cells.pop_front();
            check_field("visible", int'(want.visible), int'(i_m_tuser));
            check_field("cell_x", want.cell_x, got_cx);
            check_field("cell_y", want.cell_y, got_cy);
            check_field("screen_x", want.screen_x, got_sx);
            check_field("screen_y", want.screen_y, got_sy);
            check_field("done_res", int'(want.done_res), int'(i_m_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_width   = WIN_W_RESET;
            win_height  = WIN_H_RESET;
            walking     = 1'b0;
            depth_step  = '0;
            column_step = '0;
            reach       = '0;
            anchor_x    = '0;
            anchor_y    = '0;
            expected_cells.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_WIN_WIDTH:  win_width  = i_cfg_data;
                    CFG_WIN_HEIGHT: win_height = i_cfg_data;
                    default: ;
                endcase
            end
            // results are registered behind their item, so retire before predicting
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                expected_cells.push_back(walk_step(i_s_tuser, i_s_tdata[14:0],
                                                   i_s_tdata[29:15]));
        end
        pending_cnt = expected_cells.size();
    end

endmodule

@@ sim/tb_isometric_back_to_front_cell_walker_core.sv @@
// top of the cell walker testbench: clock, reset, stimulus and verdict
// depends on ibfcw_pkg, isometric_back_to_front_cell_walker_core and ibfcw_walk_checker
module tb_isometric_back_to_front_cell_walker_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ibfcw_pkg::*;

    localparam int TILE_W       = 64;
    localparam int TILE_H       = 64;
    localparam int STEP_H       = 32;
    localparam int STEP_V       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata;
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic                    o_m_tuser;
    logic                    o_m_tlast;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [WIN_W-1:0]        i_cfg_data;

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_sink;
    int fail_count;
    int pending;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    isometric_back_to_front_cell_walker_core #(
        .TILE_WIDTH      (TILE_W),
        .TILE_HEIGHT     (TILE_H),
        .STEP_HORIZONTAL (STEP_H),
        .STEP_VERTICAL   (STEP_V)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    ibfcw_walk_checker #(
        .TILE_WIDTH      (TILE_W),
        .TILE_HEIGHT     (TILE_H),
        .STEP_HORIZONTAL (STEP_H),
        .STEP_VERTICAL   (STEP_V)
    ) u_walk_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // result side: random back-pressure, plus one long hold when asked
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            i_m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    function automatic logic [ANCHOR_W-1:0] pick_player();
        case ($urandom_range(0, 7))
            0:       return 15'h4000;
            1:       return 15'h3fff;
            2:       return '0;
            default: return ANCHOR_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(0, 3))
            0:       return WIN_W'($urandom_range(0, 300));
            1:       return WIN_LIMIT_V;
            default: return WIN_W'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [ANCHOR_W-1:0] px,
                             input logic [ANCHOR_W-1:0] py);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, py, px};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // player fields are ignored on advance, so they carry junk
    task automatic send_advances(input int n);
        repeat (n) send_item(OP_ADVANCE, pick_player(), pick_player());
    endtask

    task automatic random_items(input int n, input int start_permille);
        repeat (n) begin
            if ($urandom_range(0, 999) < start_permille)
                send_item(OP_START, pick_player(), pick_player());
            else
                send_item(OP_ADVANCE, pick_player(), pick_player());
        end
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w, input logic [WIN_W-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= CFG_WIN_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_WIN_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = OP_START;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = CFG_WIN_WIDTH;
        i_cfg_data    = '0;
        src_idle_pct  = 19;
        sink_idle_pct = 51;
        hold_sink     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window, no walk yet, extreme anchors, back-to-back starts
        send_item(OP_ADVANCE, '0, '0);
        send_item(OP_START, 15'h3fff, 15'h4000);
        send_advances(4);
        send_item(OP_START, 15'h4000, 15'h3fff);
        send_advances(3);
        send_item(OP_START, '0, '0);
        send_item(OP_START, '1, '1);
        send_advances(5);
        settle();

        // zero window: smallest reach, one full walk and advances past its end
        write_window('0, '0);
        send_item(OP_START, pick_player(), pick_player());
        send_advances(335);
        settle();

        write_window(13'd1, WIN_LIMIT_V);
        send_item(OP_START, pick_player(), pick_player());
        random_items(75, 10);
        settle();
        random_items(75, 10);
        settle();

        // oversized window while a walk is running: reach stays as latched
        src_idle_pct  = 51;
        sink_idle_pct = 19;
        write_window(13'd8191, 13'd4097);
        random_items(120, 0);
        settle();

        write_window(13'd100, 13'd31);
        send_item(OP_START, pick_player(), pick_player());
        send_advances(440);
        settle();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int k = 0; k < 3; k++) begin
            write_window(pick_window(), pick_window());
            if (k == 1)
                hold_sink = 1'b1;
            send_item(OP_START, pick_player(), pick_player());
            random_items(100, 5);
            settle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
